### rtl/core/udpdc_pkg.sv
// Shared constants, types and helpers for the UDP datagram checker.
`timescale 1ns / 1ps

package udpdc_pkg;

   // Stream widths
   localparam int REQ_TDATA_WIDTH = 72;
   localparam int REQ_BEAT_WIDTH  = REQ_TDATA_WIDTH + 1;   // tdata plus tlast
   localparam int RSP_FIELD_BITS  = 130;
   localparam int RSP_TDATA_WIDTH = 136;
   localparam int RSP_PAD_BITS    = RSP_TDATA_WIDTH - RSP_FIELD_BITS;

   localparam logic [15:0] PROTO_UDP = 16'd17;
   localparam logic [15:0] ONES_MAX  = 16'hFFFF;
   localparam logic [15:0] HDR_LEN   = 16'd8;

   // Header byte positions
   localparam logic [15:0] POS_LEN_HI  = 16'd4;
   localparam logic [15:0] POS_LEN_LO  = 16'd5;
   localparam logic [15:0] POS_CSUM_HI = 16'd6;
   localparam logic [15:0] POS_CSUM_LO = 16'd7;

   typedef enum logic [1:0] {
      VERDICT_ACCEPT       = 2'd0,
      VERDICT_TOO_SHORT    = 2'd1,
      VERDICT_LEN_MISMATCH = 2'd2,
      VERDICT_BAD_CSUM     = 2'd3
   } verdict_type;

   // Datagram state frozen on the last byte
   typedef struct packed {
      logic [15:0] count;
      logic [15:0] sum;
      logic [7:0]  pending;
      logic [15:0] len;
      logic [15:0] csum;
      logic [31:0] ports;
   } snap_type;

   // 16-bit ones'-complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

### rtl/core/udpdc_skid.sv
// Two-entry input register with a registered ready toward the sender.
`timescale 1ns / 1ps

module udpdc_skid #(
   parameter int WIDTH_P = udpdc_pkg::REQ_BEAT_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [WIDTH_P-1:0] in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [WIDTH_P-1:0] out_data
);
   import udpdc_pkg::*;

   logic               main_valid_ff, main_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [WIDTH_P-1:0] main_data_ff, main_data_in;
   logic [WIDTH_P-1:0] skid_data_ff, skid_data_in;
   logic               take_in;
   logic               main_open;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   assign take_in   = in_valid && !skid_valid_ff;
   assign main_open = !main_valid_ff || out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (main_open) begin
         // skid entry goes first; input is blocked while it is full
         main_valid_in = skid_valid_ff || take_in;
         main_data_in  = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (take_in) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

### rtl/core/udp_datagram_checker.sv
// Top level: UDP length and checksum verifier, one datagram byte per beat.
`timescale 1ns / 1ps
//
// Usage:
//   req_*: one datagram byte per beat, header first, req_tlast on the final
//   byte. The IPv4 addresses ride along and are used on the first byte only.
//   rsp_*: one beat per datagram, issued for the req_tlast byte, carrying the
//   verdict, header fields, payload length and running accept/reject totals.
// Throughput: one byte per cycle sustained while the snapshot stage can take a
//   last byte; the per-byte ones'-complement add and header capture are
//   combinational from the input register. A last byte passes the input
//   register, then the snapshot register, then the result register to rsp_*.
// req_tready is registered; a two-entry input register absorbs the beat
//   in flight when it drops.
// Stall: while rsp_tready is low the result holds; one further finished
//   datagram waits in the snapshot stage, and bytes of the next datagram keep
//   flowing until its own last byte needs that stage.
// Reset: synchronous; clears all datagram state and both totals, and
//   empties every stage.
//
module udp_datagram_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [7:0] data_byte, [39:8] source_address, [71:40] destination_address
   input  logic [udpdc_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [1:0] verdict, [17:2] declared_length, [33:18] source_port,
   // [49:34] destination_port, [65:50] data_length, [97:66] accepted_count,
   // [129:98] rejected_count, [135:130] zero
   output logic [udpdc_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);
   import udpdc_pkg::*;

   logic                      in_valid;
   logic                      in_ready;
   logic [REQ_BEAT_WIDTH-1:0] in_beat;
   logic [7:0]                in_byte;
   logic                      in_last;
   logic [31:0]               in_saddr;
   logic [31:0]               in_daddr;

   udpdc_skid #(.WIDTH_P(REQ_BEAT_WIDTH)) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   ({req_tlast, req_tdata}),
      .out_valid (in_valid),
      .out_ready (in_ready),
      .out_data  (in_beat)
   );

   assign in_byte  = in_beat[7:0];
   assign in_saddr = in_beat[39:8];
   assign in_daddr = in_beat[71:40];
   assign in_last  = in_beat[REQ_BEAT_WIDTH-1];

   // ---------------- per-datagram state ----------------
   logic [15:0] pos_ff, pos_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  pending_ff, pending_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] csum_ff, csum_in;
   logic [31:0] ports_ff, ports_in;
   logic [31:0] accepted_ff, accepted_in;
   logic [31:0] rejected_ff, rejected_in;

   logic        snap_valid_ff, snap_valid_in;
   snap_type    snap_ff, snap_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic        out_free;
   logic        snap_free;
   logic        snap_move;
   logic        take;

   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign snap_free = !snap_valid_ff || out_free;
   assign snap_move = snap_valid_ff && out_free;
   // only the last byte needs room downstream
   assign in_ready  = !in_last || snap_free;
   assign take      = in_valid && in_ready;

   // pseudo-header sum: both addresses and the protocol; length comes at byte 5
   logic [18:0] pseudo_raw;
   logic [16:0] pseudo_fold;
   logic [15:0] pseudo_sum;

   assign pseudo_raw  = {3'd0, in_saddr[31:16]} + {3'd0, in_saddr[15:0]}
                      + {3'd0, in_daddr[31:16]} + {3'd0, in_daddr[15:0]}
                      + {3'd0, PROTO_UDP};
   assign pseudo_fold = {1'b0, pseudo_raw[15:0]} + {14'd0, pseudo_raw[18:16]};
   assign pseudo_sum  = pseudo_fold[15:0] + {15'd0, pseudo_fold[16]};

   logic        counted;
   logic [15:0] word;
   logic [15:0] add_one;
   logic [15:0] add_two;
   logic [17:0] sum_raw;
   logic [16:0] sum_fold;
   logic [15:0] sum_step;
   logic [4:0]  lane_shift;

   assign counted    = (pos_ff < POS_CSUM_HI) || (pos_ff < len_ff);
   assign word       = {pending_ff, in_byte};
   assign add_one    = (counted && pos_ff[0]) ? word : 16'd0;
   // at byte 5 the finished length word joins the sum as the pseudo-header length
   assign add_two    = (pos_ff == POS_LEN_LO) ? word : 16'd0;
   assign sum_raw    = {2'd0, sum_ff} + {2'd0, add_one} + {2'd0, add_two};
   assign sum_fold   = {1'b0, sum_raw[15:0]} + {15'd0, sum_raw[17:16]};
   assign sum_step   = sum_fold[15:0] + {15'd0, sum_fold[16]};
   assign lane_shift = {~pos_ff[1:0], 3'b000};

   logic [15:0] pos_nx;
   logic [15:0] sum_nx;
   logic [7:0]  pending_nx;
   logic [15:0] len_nx;
   logic [15:0] csum_nx;
   logic [31:0] ports_nx;

   always_comb begin
      pos_nx     = (pos_ff == ONES_MAX) ? pos_ff : pos_ff + 16'd1;
      sum_nx     = (pos_ff == 16'd0) ? pseudo_sum : sum_step;
      pending_nx = (counted && !pos_ff[0]) ? in_byte : pending_ff;
      len_nx     = len_ff;
      csum_nx    = csum_ff;
      ports_nx   = ports_ff;
      if (pos_ff < POS_LEN_HI) begin
         ports_nx = ports_ff | ({24'd0, in_byte} << lane_shift);
      end
      if (pos_ff == POS_LEN_HI) begin
         len_nx = {in_byte, 8'd0};
      end
      if (pos_ff == POS_LEN_LO) begin
         len_nx = {len_ff[15:8], in_byte};
      end
      if (pos_ff == POS_CSUM_HI) begin
         csum_nx = {in_byte, 8'd0};
      end
      if (pos_ff == POS_CSUM_LO) begin
         csum_nx = {csum_ff[15:8], in_byte};
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      pending_in = pending_ff;
      len_in     = len_ff;
      csum_in    = csum_ff;
      ports_in   = ports_ff;
      snap_in    = snap_ff;
      if (take) begin
         if (in_last) begin
            snap_in.count   = pos_nx;
            snap_in.sum     = sum_nx;
            snap_in.pending = pending_nx;
            snap_in.len     = len_nx;
            snap_in.csum    = csum_nx;
            snap_in.ports   = ports_nx;
            pos_in          = 16'd0;
            sum_in          = 16'd0;
            pending_in      = 8'd0;
            len_in          = 16'd0;
            csum_in         = 16'd0;
            ports_in        = 32'd0;
         end else begin
            pos_in     = pos_nx;
            sum_in     = sum_nx;
            pending_in = pending_nx;
            len_in     = len_nx;
            csum_in    = csum_nx;
            ports_in   = ports_nx;
         end
      end
   end

   always_comb begin
      snap_valid_in = snap_valid_ff;
      if (take && in_last) begin
         snap_valid_in = 1'b1;
      end else if (snap_move) begin
         snap_valid_in = 1'b0;
      end
   end

   // ---------------- verdict ----------------
   logic [15:0]  decl;
   verdict_type  verdict;
   logic [15:0]  final_sum;
   logic [15:0]  odd_pad;
   logic [15:0]  payload_len;

   assign odd_pad   = snap_ff.len[0] ? {snap_ff.pending, 8'd0} : 16'd0;
   assign final_sum = oc_add(snap_ff.sum, odd_pad);

   always_comb begin
      decl    = 16'd0;
      verdict = VERDICT_ACCEPT;
      priority if (snap_ff.count < HDR_LEN) begin
         verdict = VERDICT_TOO_SHORT;
      end else begin
         decl = snap_ff.len;
         priority if (decl < HDR_LEN || decl > snap_ff.count) begin
            verdict = VERDICT_LEN_MISMATCH;
         end else if (snap_ff.csum == 16'd0) begin
            // zero checksum field: sender skipped it
            verdict = VERDICT_ACCEPT;
         end else if (final_sum == ONES_MAX) begin
            verdict = VERDICT_ACCEPT;
         end else begin
            verdict = VERDICT_BAD_CSUM;
         end
      end
   end

   assign payload_len = (verdict == VERDICT_ACCEPT) ? decl - HDR_LEN : 16'd0;

   always_comb begin
      accepted_in   = accepted_ff;
      rejected_in   = rejected_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (snap_move) begin
         if (verdict == VERDICT_ACCEPT) begin
            accepted_in = accepted_ff + 32'd1;
         end else begin
            rejected_in = rejected_ff + 32'd1;
         end
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {{RSP_PAD_BITS{1'b0}}, rejected_in, accepted_in, payload_len,
                          snap_ff.ports[15:0], snap_ff.ports[31:16], decl, verdict};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= 16'd0;
         sum_ff        <= 16'd0;
         pending_ff    <= 8'd0;
         len_ff        <= 16'd0;
         csum_ff       <= 16'd0;
         ports_ff      <= 32'd0;
         accepted_ff   <= 32'd0;
         rejected_ff   <= 32'd0;
         snap_valid_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         sum_ff        <= sum_in;
         pending_ff    <= pending_in;
         len_ff        <= len_in;
         csum_ff       <= csum_in;
         ports_ff      <= ports_in;
         accepted_ff   <= accepted_in;
         rejected_ff   <= rejected_in;
         snap_valid_ff <= snap_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      snap_ff      <= snap_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

### rtl/core/udpdc_checker.sv
// Port-level assertions for the UDP datagram checker, bound to the top level.
`timescale 1ns / 1ps

module udpdc_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [udpdc_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   input logic                                  req_tlast,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [udpdc_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);
   import udpdc_pkg::*;

   logic [1:0]  verdict;
   logic [15:0] decl;
   logic [15:0] dlen;
   logic [31:0] total_now;
   logic [31:0] total_ff, total_in;
   logic [31:0] total_expect;

   assign verdict      = rsp_tdata[1:0];
   assign decl         = rsp_tdata[17:2];
   assign dlen         = rsp_tdata[65:50];
   assign total_now    = rsp_tdata[97:66] + rsp_tdata[129:98];
   assign total_expect = total_ff + 32'd1;
   assign total_in     = (rsp_tvalid && rsp_tready) ? total_now : total_ff;

   // datagram total as of the last delivered result
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 32'd0;
      end else begin
         total_ff <= total_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   a_accept_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && verdict == VERDICT_ACCEPT |-> decl >= HDR_LEN && dlen == decl - HDR_LEN)
      else $error("accepted datagram with inconsistent lengths");

   a_reject_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && verdict != VERDICT_ACCEPT |->
         dlen == 16'd0 && (verdict != VERDICT_TOO_SHORT || decl == 16'd0))
      else $error("rejected datagram reports a length");

   a_one_per_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> total_now == total_expect)
      else $error("totals did not advance by exactly one");

endmodule

bind udp_datagram_checker udpdc_checker u_udpdc_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench for the UDP datagram checker: directed and random datagrams.
`timescale 1ns / 1ps

module testbench;
   import udpdc_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      verdict_type verdict;
      logic [15:0] declared_length;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [15:0] data_length;
      logic [31:0] accepted_count;
      logic [31:0] rejected_count;
   } rsp_expect_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata;
   logic                       req_tlast;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;

   // verdicts predicted for datagrams whose last byte has gone in
   rsp_expect_type expected_verdicts[$];
   // datagram under construction
   logic [7:0]   frame[$];

   // mirror of the checker's datagram state
   logic [15:0] dg_pos;
   logic [15:0] dg_sum;
   logic [7:0]  dg_high;
   logic [15:0] dg_len;
   logic [15:0] dg_csum;
   logic [31:0] dg_ports;
   logic [31:0] accepted_total;
   logic [31:0] rejected_total;

   int  errors;
   int  cycle_count;
   int  bytes_sent;
   int  datagrams_sent;
   int  longest_datagram;
   int  sink_stall;
   bit  idle_on;
   bit  verdict_seen[4];

   udp_datagram_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
                  expected_verdicts.size());
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] wide;
      wide = {1'b0, a} + {1'b0, b};
      return wide[15:0] + {15'd0, wide[16]};
   endfunction

   function automatic logic [15:0] pseudo_sum(input logic [31:0] sa, input logic [31:0] da);
      logic [15:0] s;
      s = ones_add(sa[31:16], sa[15:0]);
      s = ones_add(s, da[31:16]);
      s = ones_add(s, da[15:0]);
      return ones_add(s, PROTO_UDP);
   endfunction

   task automatic clear_datagram_state();
      dg_pos   = '0;
      dg_sum   = '0;
      dg_high  = '0;
      dg_len   = '0;
      dg_csum  = '0;
      dg_ports = '0;
   endtask

   // Advance the mirror by one accepted byte; on the last byte queue the verdict.
   task automatic predict_byte(input logic [7:0] b, input logic last, input logic [31:0] sa,
                               input logic [31:0] da);
      rsp_expect_type r;
      logic [15:0]  s;
      int           shift;
      if (dg_pos == 0)
         dg_sum = pseudo_sum(sa, da);
      if (dg_pos < 4) begin
         shift = 8 * (3 - int'(dg_pos));
         dg_ports[shift +: 8] = b;
      end else if (dg_pos == POS_LEN_HI) begin
         dg_len = {b, 8'h00};
      end else if (dg_pos == POS_LEN_LO) begin
         dg_len[7:0] = b;
      end else if (dg_pos == POS_CSUM_HI) begin
         dg_csum = {b, 8'h00};
      end else if (dg_pos == POS_CSUM_LO) begin
         dg_csum[7:0] = b;
      end
      // bytes past the declared length stay out of the sum
      if (dg_pos < 6 || dg_pos < dg_len) begin
         if (!dg_pos[0])
            dg_high = b;
         else
            dg_sum = ones_add(dg_sum, {dg_high, b});
      end
      // UDP length enters the pseudo-header as soon as it is known
      if (dg_pos == POS_LEN_LO)
         dg_sum = ones_add(dg_sum, dg_len);
      if (dg_pos != 16'hFFFF)
         dg_pos++;
      bytes_sent++;
      if (last) begin
         r.declared_length = '0;
         r.data_length     = '0;
         if (dg_pos < HDR_LEN) begin
            r.verdict = VERDICT_TOO_SHORT;
         end else begin
            r.declared_length = dg_len;
            if (dg_len < HDR_LEN || dg_len > dg_pos) begin
               r.verdict = VERDICT_LEN_MISMATCH;
            end else if (dg_csum == 0) begin
               r.verdict = VERDICT_ACCEPT;
            end else begin
               s = dg_sum;
               if (dg_len[0])
                  s = ones_add(s, {dg_high, 8'h00});
               r.verdict = (s == ONES_MAX) ? VERDICT_ACCEPT : VERDICT_BAD_CSUM;
            end
         end
         if (r.verdict == VERDICT_ACCEPT) begin
            accepted_total++;
            r.data_length = r.declared_length - HDR_LEN;
         end else begin
            rejected_total++;
         end
         r.source_port      = dg_ports[31:16];
         r.destination_port = dg_ports[15:0];
         r.accepted_count   = accepted_total;
         r.rejected_count   = rejected_total;
         expected_verdicts.push_back(r);
         verdict_seen[r.verdict] = 1'b1;
         datagrams_sent++;
         clear_datagram_state();
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the beat went in.
   task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] sa,
                            input logic [31:0] da);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         req_tdata  <= {8'($urandom), $urandom, $urandom};
         req_tlast  <= 1'($urandom_range(0, 1));
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {da, sa, b};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_byte(b, last, sa, da);
      @(negedge clock);
   endtask

   // Only the first byte's addresses count; later bytes carry junk addresses.
   task automatic send_frame(input logic [31:0] sa, input logic [31:0] da);
      for (int i = 0; i < frame.size(); i++) begin
         if (i == 0)
            send_byte(frame[i], frame.size() == 1, sa, da);
         else
            send_byte(frame[i], i == frame.size() - 1, $urandom, $urandom);
      end
      if (frame.size() > longest_datagram)
         longest_datagram = frame.size();
   endtask

   // Well-formed datagram with a valid checksum (or zero when asked).
   task automatic build_datagram(input int payload_len, input logic [15:0] sport,
                                 input logic [15:0] dport, input logic [31:0] sa,
                                 input logic [31:0] da, input bit zero_csum);
      logic [15:0] len;
      logic [15:0] s;
      logic [15:0] csum;
      len = 16'(payload_len + 8);
      frame.delete();
      frame.push_back(sport[15:8]);
      frame.push_back(sport[7:0]);
      frame.push_back(dport[15:8]);
      frame.push_back(dport[7:0]);
      frame.push_back(len[15:8]);
      frame.push_back(len[7:0]);
      frame.push_back(8'h00);
      frame.push_back(8'h00);
      for (int i = 0; i < payload_len; i++)
         frame.push_back(8'($urandom));
      s = ones_add(pseudo_sum(sa, da), len);
      for (int i = 0; i < frame.size(); i += 2)
         s = ones_add(s, {frame[i], (i + 1 < frame.size()) ? frame[i + 1] : 8'h00});
      csum = ~s;
      if (csum == 0)
         csum = 16'hFFFF;
      if (zero_csum)
         csum = 16'h0000;
      frame[6] = csum[15:8];
      frame[7] = csum[7:0];
   endtask

   task automatic build_noise(input int n);
      frame.delete();
      for (int i = 0; i < n; i++)
         frame.push_back(8'($urandom));
   endtask

   task automatic set_length_field(input logic [15:0] len);
      frame[4] = len[15:8];
      frame[5] = len[7:0];
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (expected_verdicts.size() != 0)
         @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_expect_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verdicts.size() == 0) begin
            $error("result beat with no datagram outstanding");
            errors++;
         end else begin
            want = expected_verdicts.pop_front();
            check_field("verdict", 32'(want.verdict), 32'(rsp_tdata[1:0]));
            check_field("declared_length", 32'(want.declared_length),
                        32'(rsp_tdata[17:2]));
            check_field("source_port", 32'(want.source_port), 32'(rsp_tdata[33:18]));
            check_field("destination_port", 32'(want.destination_port),
                        32'(rsp_tdata[49:34]));
            check_field("data_length", 32'(want.data_length), 32'(rsp_tdata[65:50]));
            check_field("accepted_count", want.accepted_count, rsp_tdata[97:66]);
            check_field("rejected_count", want.rejected_count, rsp_tdata[129:98]);
         end
      end
   end

   // result-side backpressure in random bursts
   always @(negedge clock) begin
      if (sink_stall > 0) begin
         sink_stall--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         sink_stall = $urandom_range(1, 10) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic test_accept();
      build_datagram(0, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_frame(32'h0000_0000, 32'h0000_0000);
      build_datagram(1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      build_datagram(6, 16'h8001, 16'h0035, 32'hC0A8_0001, 32'h0A00_00FE, 1'b0);
      send_frame(32'hC0A8_0001, 32'h0A00_00FE);
      build_datagram(3, 16'h1234, 16'hABCD, $urandom, $urandom, 1'b0);
      send_frame($urandom, $urandom);   // addresses differ: checksum goes bad
   endtask

   task automatic test_zero_checksum();
      logic [31:0] sa;
      logic [31:0] da;
      sa = $urandom;
      da = $urandom;
      build_datagram(5, 16'h4000, 16'h0044, sa, da, 1'b1);
      frame[9] = ~frame[9];   // payload garbage is not verified
      send_frame(sa, da);
   endtask

   task automatic test_bad_checksum();
      logic [31:0] sa;
      logic [31:0] da;
      sa = $urandom;
      da = $urandom;
      build_datagram(8, 16'h0007, 16'h0009, sa, da, 1'b0);
      frame[12] = frame[12] ^ 8'h10;
      send_frame(sa, da);
   endtask

   task automatic test_excess_bytes();
      logic [31:0] sa;
      logic [31:0] da;
      sa = $urandom;
      da = $urandom;
      build_datagram(3, 16'h0400, 16'h0800, sa, da, 1'b0);
      repeat (5) frame.push_back(8'($urandom));
      send_frame(sa, da);
   endtask

   task automatic test_length_errors();
      logic [31:0] sa;
      logic [31:0] da;
      sa = $urandom;
      da = $urandom;
      build_datagram(10, 16'h1111, 16'h2222, sa, da, 1'b0);
      repeat (4) void'(frame.pop_back());   // declared length exceeds what arrived
      send_frame(sa, da);
      build_datagram(2, 16'h3333, 16'h4444, sa, da, 1'b0);
      set_length_field(16'd7);
      send_frame(sa, da);
      build_datagram(0, 16'h5555, 16'h6666, sa, da, 1'b0);
      set_length_field(16'd0);
      send_frame(sa, da);
      build_datagram(12, 16'h7777, 16'h8888, sa, da, 1'b0);
      set_length_field(16'hFFFF);
      send_frame(sa, da);
   endtask

   task automatic test_too_short();
      build_noise(1);
      send_frame($urandom, $urandom);
      build_noise(5);
      send_frame($urandom, $urandom);
      build_noise(7);
      send_frame($urandom, $urandom);
   endtask

   task automatic test_random_traffic();
      int          start_bytes;
      int          start_dgrams;
      int          kind;
      int          plen;
      bit          drained;
      logic [31:0] sa;
      logic [31:0] da;
      start_bytes  = bytes_sent;
      start_dgrams = datagrams_sent;
      drained      = 1'b0;
      while (bytes_sent - start_bytes < 1000 || datagrams_sent - start_dgrams < 48) begin
         if (bytes_sent - start_bytes >= 850)
            idle_on = 1'b0;
         if (!drained && bytes_sent - start_bytes >= 400) begin
            wait_for_drain();
            drained = 1'b1;
         end
         sa   = $urandom;
         da   = $urandom;
         kind = $urandom_range(0, 99);
         plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40);
         if (kind < 94)
            build_datagram(plen, 16'($urandom), 16'($urandom), sa, da,
                           $urandom_range(0, 15) == 0);
         if (kind >= 65 && kind < 75) begin
            frame[$urandom_range(0, frame.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
         end else if (kind >= 75 && kind < 83) begin
            repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
         end else if (kind >= 83 && kind < 89) begin
            repeat ($urandom_range(1, 7)) void'(frame.pop_back());
            if (frame.size() == 0)
               frame.push_back(8'($urandom));
         end else if (kind >= 89 && kind < 94) begin
            build_noise($urandom_range(1, 7));
         end else if (kind >= 94) begin
            build_noise($urandom_range(1, 24));
         end
         send_frame(sa, da);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b1;
      errors      = 0;
      cycle_count = 0;
      sink_stall  = 0;
      idle_on     = 1'b1;
      bytes_sent  = 0;
      datagrams_sent   = 0;
      longest_datagram = 0;
      clear_datagram_state();
      accepted_total = '0;
      rejected_total = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_accept();
      test_zero_checksum();
      test_bad_checksum();
      test_excess_bytes();
      test_length_errors();
      test_too_short();
      test_random_traffic();

      wait_for_drain();
      repeat (8) @(negedge clock);

      $display("Sent %0d datagrams in %0d bytes (longest %0d): %0d accepted, %0d rejected.",
               datagrams_sent, bytes_sent, longest_datagram, accepted_total, rejected_total);
      $display("Verdicts seen: accept=%0d too_short=%0d length_mismatch=%0d bad_checksum=%0d",
               verdict_seen[VERDICT_ACCEPT], verdict_seen[VERDICT_TOO_SHORT],
               verdict_seen[VERDICT_LEN_MISMATCH], verdict_seen[VERDICT_BAD_CSUM]);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/udpdc_pkg.sv
rtl/core/udpdc_skid.sv
rtl/core/udp_datagram_checker.sv
rtl/core/udpdc_checker.sv
tb/sv/testbench.sv
